// ----- rtl/core/basedec_pkg.sv -----
// Shared types and the character classifier for the base64 decoder.
// No dependencies; every other file imports this package.
package basedec_pkg;

  // Pad character code
  localparam logic [7:0] PadChar = 8'h3D;

  // Character class as seen by the front end
  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_PAD,
    CLS_BAD
  } cls_e;

  // Classified character passed from front to back
  typedef struct packed {
    cls_e       cls;
    logic [5:0] sextet;
    logic       last;
  } item_t;

  // One result as it sits in the output queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_end;
    logic       error;
  } result_t;

  // Map a character to its class and 6-bit value
  function automatic item_t classify(input logic [7:0] sym, input logic last);
    item_t it;
    it.cls    = CLS_BAD;
    it.sextet = 6'd0;
    it.last   = last;
    if (sym >= 8'h41 && sym <= 8'h5A) begin
      it.cls    = CLS_DATA;
      it.sextet = 6'(sym - 8'h41);
    end else if (sym >= 8'h61 && sym <= 8'h7A) begin
      it.cls    = CLS_DATA;
      it.sextet = 6'(sym - 8'h61 + 8'd26);
    end else if (sym >= 8'h30 && sym <= 8'h39) begin
      it.cls    = CLS_DATA;
      it.sextet = 6'(sym - 8'h30 + 8'd52);
    end else if (sym == 8'h2B) begin
      it.cls    = CLS_DATA;
      it.sextet = 6'd62;
    end else if (sym == 8'h2F) begin
      it.cls    = CLS_DATA;
      it.sextet = 6'd63;
    end else if (sym == PadChar) begin
      it.cls    = CLS_PAD;
    end
    return it;
  endfunction

endpackage

// ----- rtl/core/basedec_front.sv -----
// Front end of the base64 decoder: accepts characters, classifies them and
// holds them in a two-entry queue for the back end. Depends on basedec_pkg.
module basedec_front
  import basedec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_pop_i
);

  item_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       wr_en;
  logic       rd_en;

  // Take a request whenever a slot is free
  assign full         = (count_q == 2'd2);
  assign wr_en        = push && !full;
  assign item_valid_o = (count_q != 2'd0);
  assign rd_en        = item_pop_i && item_valid_o;
  assign item_o       = entry_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) wr_ptr_d = !wr_ptr_q;
    if (rd_en) rd_ptr_d = !rd_ptr_q;
    if (wr_en && !rd_en) count_d = count_q + 2'd1;
    else if (!wr_en && rd_en) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified character
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= classify(symbol_i, last_i);
    end
  end

endmodule

// ----- rtl/core/basedec_outq.sv -----
// Four-entry result queue at the output of the base64 decoder.
// Depends on basedec_pkg for the result type.
module basedec_outq
  import basedec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_en_i,
  input  result_t wr_data_i,
  output logic    full_o,
  input  logic    pop,
  output logic    empty,
  output result_t rd_data_o
);

  result_t    entry_q [4];
  logic [1:0] wr_ptr_q;
  logic [1:0] rd_ptr_q;
  logic [2:0] count_q, count_d;
  logic       wr_ok;
  logic       rd_ok;

  assign full_o    = (count_q == 3'd4);
  assign empty     = (count_q == 3'd0);
  assign wr_ok     = wr_en_i && !full_o;
  assign rd_ok     = pop && !empty;
  assign rd_data_o = entry_q[rd_ptr_q];

  // Track occupancy
  always_comb begin
    count_d = count_q;
    if (wr_ok && !rd_ok) count_d = count_q + 3'd1;
    else if (!wr_ok && rd_ok) count_d = count_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      if (wr_ok) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (rd_ok) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_d;
    end
  end

  // Hold result data
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Occupancy never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 3'd4)
    else $error("outq overflow");

  // Writer never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en_i |-> !full_o)
    else $error("outq write while full");

endmodule

// ----- rtl/core/basedec_back.sv -----
// Back end of the base64 decoder: holds the group position, partial byte
// and flags, and writes byte and end results. Depends on basedec_pkg.
module basedec_back
  import basedec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  output logic    res_wr_o,
  output result_t res_o,
  input  logic    res_full_i
);

  logic [1:0] position_q, position_d;
  logic [7:0] partial_q, partial_d;
  logic       pad_seen_q, pad_seen_d;
  logic       error_seen_q, error_seen_d;
  logic       byte_done_q, byte_done_d;
  logic       emit_byte;
  logic       push_byte;
  logic       push_end;
  logic [7:0] byte_val;
  logic       end_bad;

  // Decide which result the head item owes next
  assign emit_byte = (item_i.cls == CLS_DATA) && !pad_seen_q && !error_seen_q
                     && (position_q != 2'd0);
  assign push_byte = item_valid_i && emit_byte && !byte_done_q;
  assign push_end  = item_valid_i && item_i.last && !(emit_byte && !byte_done_q);
  assign res_wr_o  = (push_byte || push_end) && !res_full_i;

  // Assemble the byte from the remainder and the new sextet
  always_comb begin
    unique case (position_q)
      2'd1:    byte_val = partial_q | {6'd0, item_i.sextet[5:4]};
      2'd2:    byte_val = partial_q | {4'd0, item_i.sextet[5:2]};
      2'd3:    byte_val = partial_q | {2'd0, item_i.sextet};
      default: byte_val = partial_q;
    endcase
  end

  // Next state of the group decoder for the head item
  always_comb begin
    position_d   = position_q + 2'd1;
    partial_d    = partial_q;
    pad_seen_d   = pad_seen_q;
    error_seen_d = error_seen_q;
    priority if (item_i.cls == CLS_PAD) begin
      pad_seen_d = 1'b1;
    end else if (pad_seen_q || item_i.cls == CLS_BAD) begin
      error_seen_d = 1'b1;
    end else if (!error_seen_q) begin
      unique case (position_q)
        2'd0:    partial_d = {item_i.sextet, 2'd0};
        2'd1:    partial_d = {item_i.sextet[3:0], 4'd0};
        2'd2:    partial_d = {item_i.sextet[1:0], 6'd0};
        default: partial_d = partial_q;
      endcase
    end
  end

  assign end_bad = error_seen_d || (position_d != 2'd0);

  always_comb begin
    res_o.data_byte = push_byte ? byte_val : 8'd0;
    res_o.is_end    = !push_byte;
    res_o.error     = !push_byte && end_bad;
  end

  // Pop the head once it owes no more results
  always_comb begin
    if (push_byte) item_pop_o = !res_full_i && !item_i.last;
    else if (push_end) item_pop_o = !res_full_i;
    else item_pop_o = item_valid_i;

    byte_done_d = byte_done_q;
    if (push_byte && !res_full_i && item_i.last) byte_done_d = 1'b1;
    else if (item_pop_o) byte_done_d = 1'b0;
  end

  // Commit state on pop; clear it after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q   <= 2'd0;
      partial_q    <= 8'd0;
      pad_seen_q   <= 1'b0;
      error_seen_q <= 1'b0;
      byte_done_q  <= 1'b0;
    end else begin
      byte_done_q <= byte_done_d;
      if (item_pop_o) begin
        if (item_i.last) begin
          position_q   <= 2'd0;
          partial_q    <= 8'd0;
          pad_seen_q   <= 1'b0;
          error_seen_q <= 1'b0;
        end else begin
          position_q   <= position_d;
          partial_q    <= partial_d;
          pad_seen_q   <= pad_seen_d;
          error_seen_q <= error_seen_d;
        end
      end
    end
  end

  // A delivered byte awaiting its end result belongs to a last character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_done_q |-> (item_valid_i && item_i.last))
    else $error("byte_done without pending last item");

  // Never owe a byte and an end result in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_byte && push_end))
    else $error("byte and end requested together");

  // Once the byte is out, the next request for that item is the end result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_done_q |-> (push_end && !push_byte))
    else $error("end result not next after byte");

endmodule

// ----- rtl/core/base64_decoder.sv -----
// Top level of the streaming base64 decoder (standard alphabet, '=' pad).
// Depends on basedec_pkg, basedec_front, basedec_back and basedec_outq.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------
//   input    | push / full        | symbol_i[7:0], last_i
//   result   | empty / pop        | data_byte_o[7:0], is_end_o, error_o
//
// One character is taken per cycle while the front queue is not full. The front
// queue registers the classified character on acceptance; the back end decodes it
// into the result queue once it is at the head, and a byte can be popped from there.
// A last character that also completes a byte stays at the head until both of its
// results, the byte and then the end result, are written into the output queue.
// Reset clears all queues and decode state; no clearing pass is needed.
// The front queue (2 entries) and result queue (4 entries) absorb stalls.
module base64_decoder
  import basedec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       is_end_o,
  output logic       error_o
);

  logic    item_valid;
  item_t   item;
  logic    item_pop;
  logic    res_wr;
  result_t res_wdata;
  logic    res_full;
  result_t res_rdata;

  basedec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .symbol_i     (symbol_i),
    .last_i       (last_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  basedec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_wr_o     (res_wr),
    .res_o        (res_wdata),
    .res_full_i   (res_full)
  );

  basedec_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_wr),
    .wr_data_i (res_wdata),
    .full_o    (res_full),
    .pop       (pop),
    .empty     (empty),
    .rd_data_o (res_rdata)
  );

  assign data_byte_o = res_rdata.data_byte;
  assign is_end_o    = res_rdata.is_end;
  assign error_o     = res_rdata.error;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for base64_decoder: directed groups, then random messages.
// Predicts decoded bytes and end status per character; depends on basedec_pkg.
module testbench;
  import basedec_pkg::*;

  // Directed row: one character, with the end status typed in where obvious
  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       typed;
    logic       exp_err;
  } dir_row_t;

  localparam int NumDirRows = 24;
  localparam int ItemsPerPhase = 400;

  localparam dir_row_t DirRows [NumDirRows] = '{
    // "TWFu" decodes to "Man"; the last character also completes a byte
    '{"T", 1'b0, 1'b0, 1'b0}, '{"W", 1'b0, 1'b0, 1'b0},
    '{"F", 1'b0, 1'b0, 1'b0}, '{"u", 1'b1, 1'b1, 1'b0},
    // all ones
    '{"/", 1'b0, 1'b0, 1'b0}, '{"/", 1'b0, 1'b0, 1'b0},
    '{"/", 1'b0, 1'b0, 1'b0}, '{"/", 1'b1, 1'b1, 1'b0},
    // two pads at the end of a group
    '{"Q", 1'b0, 1'b0, 1'b0}, '{"Q", 1'b0, 1'b0, 1'b0},
    '{"=", 1'b0, 1'b0, 1'b0}, '{"=", 1'b1, 1'b1, 1'b0},
    // pads early in a group are accepted
    '{"A", 1'b0, 1'b0, 1'b0}, '{"=", 1'b0, 1'b0, 1'b0},
    '{"=", 1'b0, 1'b0, 1'b0}, '{"=", 1'b1, 1'b1, 1'b0},
    // data after a pad
    '{"Q", 1'b0, 1'b0, 1'b0}, '{"Q", 1'b0, 1'b0, 1'b0},
    '{"=", 1'b0, 1'b0, 1'b0}, '{"A", 1'b1, 1'b1, 1'b1},
    // character outside the alphabet, lone in its message
    '{8'h00, 1'b1, 1'b1, 1'b1},
    // length not a multiple of four
    '{"Q", 1'b0, 1'b0, 1'b0}, '{"Q", 1'b0, 1'b0, 1'b0},
    '{"Q", 1'b1, 1'b1, 1'b1}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] symbol_i = 8'h00;
  logic       last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] data_byte_o;
  logic       is_end_o;
  logic       error_o;

  // Predictor state
  logic [1:0] grp_pos = 2'd0;
  logic [7:0] partial_bits = 8'h00;
  logic       pad_seen = 1'b0;
  logic       err_seen = 1'b0;

  result_t pending_results [$];
  int      mismatch_count = 0;
  int      items_accepted = 0;
  int      tx_idle_pct = 26;
  int      rx_idle_pct = 51;

  base64_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .symbol_i    (symbol_i),
    .last_i      (last_i),
    .empty       (empty),
    .pop         (pop),
    .data_byte_o (data_byte_o),
    .is_end_o    (is_end_o),
    .error_o     (error_o)
  );

  always #5 clk_i = ~clk_i;

  // Six-bit value of an alphabet character, -1 for anything else
  function automatic int sextet_value(input logic [7:0] c);
    if (c inside {["A":"Z"]}) return int'(c) - int'("A");
    if (c inside {["a":"z"]}) return int'(c) - int'("a") + 26;
    if (c inside {["0":"9"]}) return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  // Alphabet character for a six-bit value
  function automatic logic [7:0] sextet_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'("+") : 8'("/");
  endfunction

  // Advance the predicted decode state by one character, queue its results
  function automatic void decode_char(input logic [7:0] c, input logic lst);
    int         v;
    logic [7:0] u;
    result_t    r;
    v = sextet_value(c);
    u = 8'(v);
    if (c == PadChar) begin
      pad_seen = 1'b1;
    end else if (pad_seen || v < 0) begin
      err_seen = 1'b1;
    end else if (!err_seen) begin
      r = '{data_byte: 8'h00, is_end: 1'b0, error: 1'b0};
      case (grp_pos)
        2'd0: begin
          partial_bits = u << 2;
        end
        2'd1: begin
          r.data_byte = partial_bits | (u >> 4);
          partial_bits = (u & 8'h0f) << 4;
          pending_results.push_back(r);
        end
        2'd2: begin
          r.data_byte = partial_bits | (u >> 2);
          partial_bits = (u & 8'h03) << 6;
          pending_results.push_back(r);
        end
        default: begin
          r.data_byte = partial_bits | u;
          pending_results.push_back(r);
        end
      endcase
    end
    grp_pos = grp_pos + 2'd1;
    if (lst) begin
      r = '{data_byte: 8'h00, is_end: 1'b1, error: err_seen || grp_pos != 2'd0};
      pending_results.push_back(r);
      grp_pos = 2'd0;
      partial_bits = 8'h00;
      pad_seen = 1'b0;
      err_seen = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one request after a random gap; predict once it is taken
  task automatic send_char(input logic [7:0] c, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    symbol_i <= c;
    last_i <= lst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    decode_char(c, lst);
    items_accepted++;
    @(negedge clk_i);
  endtask

  // Well-formed message with random content, or a noisy one
  task automatic send_message(input bit clean);
    int n_chars;
    int n_pads;
    int kind;
    logic [7:0] c;
    if (clean) begin
      n_chars = 4 * $urandom_range(1, 5);
      n_pads = $urandom_range(0, 2);
    end else begin
      n_chars = $urandom_range(1, 10);
      n_pads = 0;
    end
    for (int i = 0; i < n_chars; i++) begin
      if (clean) begin
        c = (i >= n_chars - n_pads) ? PadChar : sextet_char($urandom_range(63));
      end else begin
        kind = $urandom_range(9);
        if (kind < 6) c = sextet_char($urandom_range(63));
        else if (kind < 8) c = PadChar;
        else c = 8'($urandom_range(255));
      end
      send_char(c, i == n_chars - 1);
    end
  endtask

  // Drop the pop line at random
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare each popped result with the oldest prediction
  always @(posedge clk_i) begin : check_result
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, byte", data_byte_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (is_end_o !== want.is_end) report_mismatch("is_end", is_end_o, want.is_end);
        if (error_o !== want.error) report_mismatch("error", error_o, want.error);
        if (data_byte_o !== want.data_byte) begin
          report_mismatch("data_byte", data_byte_o, want.data_byte);
        end
      end
    end
  end

  // Hold reset, run directed rows, then three random phases
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      send_char(DirRows[i].sym, DirRows[i].last);
      if (DirRows[i].typed) pending_results[$].error = DirRows[i].exp_err;
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 51 : 0;
      rx_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 26 : 0;
      items_accepted = 0;
      while (items_accepted < ItemsPerPhase) send_message($urandom_range(99) < 80);
    end
    push <= 1'b0;

    // Drain, then allow the pipeline to settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/basedec_pkg.sv
rtl/core/basedec_front.sv
rtl/core/basedec_outq.sv
rtl/core/basedec_back.sv
rtl/core/base64_decoder.sv
tb/sv/testbench.sv
